// ===== rtl/tst_pkg.sv =====
// Shared types and constants for the timer slot table with event flags.
`default_nettype none

package tst_pkg;

  // Default configuration
  localparam int unsigned SLOTS_DEF       = 16;
  localparam int unsigned TIME_BITS_DEF   = 32;
  localparam int unsigned EVENT_COUNT_DEF = 16;

  // Fixed field widths
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned DUR_W    = 32;
  localparam int unsigned EV_W     = 4;
  localparam int unsigned FLAGS_W  = 16;
  localparam int unsigned STATUS_W = 2;

  // Function codes; the two unused codes fall to the default arm
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET    = 3'd0,
    FUNC_START  = 3'd1,
    FUNC_CANCEL = 3'd2,
    FUNC_TICK   = 3'd3,
    FUNC_CLEAR  = 3'd4,
    FUNC_READ   = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_NO_SLOT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_FREE  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_RUN   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TEVAL,
    S_RESP
  } state_e;

  // Operation applied to the slot table in the current cycle
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ALLOC,
    OP_ARM,
    OP_CANCEL,
    OP_EXPIRE
  } slot_op_e;

  // Sequencer to datapath control
  typedef struct packed {
    slot_op_e op;
    logic     now_inc;
    logic     flag_clr;
    logic     out_load;
    status_e  status;
  } seq_ctl_t;

  // Slot table to sequencer status
  typedef struct packed {
    logic free_hit;
    logic alloc_hit;
    logic fire;
  } slot_sts_t;

endpackage

`default_nettype wire

// ===== rtl/tst_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none

module tst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tst_slot_table.sv =====
// Slot table: per-slot mode and id registers, slot RAMs and the expiry compare.
`default_nettype none

module tst_slot_table #(
  parameter int unsigned SLOTS     = tst_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = tst_pkg::TIME_BITS_DEF,
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tst_pkg::slot_op_e             op_i,
  input  wire logic [IDX_W-1:0]              idx_i,
  input  wire logic [IDX_W-1:0]              rd_idx_i,
  input  wire logic [tst_pkg::ID_W-1:0]      id_i,
  input  wire logic [tst_pkg::EV_W-1:0]      ev_i,
  input  wire logic [TIME_BITS-1:0]          len_i,
  input  wire logic [TIME_BITS-1:0]          now_i,
  output tst_pkg::slot_sts_t                 sts_o,
  output logic      [tst_pkg::EV_W-1:0]      fire_ev_o
);

  import tst_pkg::*;

  localparam int unsigned CFG_W = EV_W + ID_W + TIME_BITS;

  mode_e            mode_q  [SLOTS];
  logic [ID_W-1:0]  timer_q [SLOTS];
  logic [SLOTS-1:0] match_id;
  logic [SLOTS-1:0] match_fire;

  logic [CFG_W-1:0]     cfg_rd;
  logic [TIME_BITS-1:0] start_rd;
  logic [EV_W-1:0]      rd_ev;
  logic [ID_W-1:0]      rd_timer;
  logic [TIME_BITS-1:0] rd_len;
  logic [TIME_BITS-1:0] elapsed;
  logic                 cfg_we;
  logic                 start_we;
  logic [TIME_BITS-1:0] start_wdata;

  assign {rd_ev, rd_timer, rd_len} = cfg_rd;

  // Wrapping elapsed time of the slot under evaluation
  assign elapsed = now_i - start_rd;

  assign sts_o.free_hit  = (mode_q[idx_i] == MODE_FREE);
  assign sts_o.alloc_hit = (mode_q[idx_i] != MODE_FREE) && match_id[idx_i];
  assign sts_o.fire      = (mode_q[idx_i] == MODE_RUN) && (elapsed >= rd_len);
  assign fire_ev_o       = rd_ev;

  // Per-slot id compare, mode and id registers
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    assign match_id[i]   = (timer_q[i] == id_i);
    assign match_fire[i] = (timer_q[i] == rd_timer);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mode_q[i] <= MODE_FREE;
      end else begin
        unique case (op_i)
          OP_ALLOC: begin
            if (idx_i == IDX_W'(i)) mode_q[i] <= MODE_ALLOC;
          end
          OP_ARM: begin
            if (idx_i == IDX_W'(i)) mode_q[i] <= MODE_RUN;
          end
          OP_CANCEL: begin
            if (match_id[i]) mode_q[i] <= MODE_FREE;
          end
          OP_EXPIRE: begin
            if (sts_o.fire && match_fire[i]) mode_q[i] <= MODE_FREE;
          end
          default: ;
        endcase
      end
    end

    always_ff @(posedge clk_i) begin
      if (op_i == OP_ALLOC && idx_i == IDX_W'(i)) begin
        timer_q[i] <= id_i;
      end
    end
  end

  // Slot RAM write controls; set clears the start stamp
  assign cfg_we      = (op_i == OP_ALLOC);
  assign start_we    = (op_i == OP_ALLOC) || (op_i == OP_ARM);
  assign start_wdata = (op_i == OP_ARM) ? now_i : '0;

  tst_ram #(
    .WIDTH (CFG_W),
    .DEPTH (SLOTS)
  ) u_cfg_ram (
    .clk_i   (clk_i),
    .we_i    (cfg_we),
    .waddr_i (idx_i),
    .wdata_i ({ev_i, id_i, len_i}),
    .raddr_i (rd_idx_i),
    .rdata_o (cfg_rd)
  );

  tst_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (SLOTS)
  ) u_start_ram (
    .clk_i   (clk_i),
    .we_i    (start_we),
    .waddr_i (idx_i),
    .wdata_i (start_wdata),
    .raddr_i (rd_idx_i),
    .rdata_o (start_rd)
  );

endmodule

`default_nettype wire

// ===== rtl/tst_ctrl.sv =====
// Sequencer: walks the slot index for set, start and tick, and hands off the result.
`default_nettype none

module tst_ctrl #(
  parameter int unsigned SLOTS = tst_pkg::SLOTS_DEF,
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire tst_pkg::func_e     func_i,
  input  wire logic               out_free_i,
  input  wire tst_pkg::slot_sts_t sts_i,
  output tst_pkg::seq_ctl_t       ctl_o,
  output logic      [IDX_W-1:0]   idx_o,
  output logic      [IDX_W-1:0]   rd_idx_o,
  output logic                    busy_o
);

  import tst_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  status_e          status_q, status_d;
  logic             last;

  assign last = (idx_q == IDX_W'(SLOTS - 1));

  // State, index and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      status_q <= status_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        unique case (func_i)
          FUNC_SET:   if (sts_i.free_hit || last) state_d = S_RESP;
          FUNC_START: if (sts_i.alloc_hit || last) state_d = S_RESP;
          FUNC_TICK:  state_d = S_TEVAL;
          default:    state_d = S_RESP;
        endcase
      end
      S_TEVAL: begin
        if (last) state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Slot index and status
  always_comb begin
    idx_d    = idx_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        idx_d    = '0;
        status_d = ST_OK;
      end
      S_SCAN: begin
        unique case (func_i)
          FUNC_SET: begin
            if (!sts_i.free_hit) begin
              if (last) status_d = ST_NO_FREE;
              else      idx_d    = idx_q + 1'b1;
            end
          end
          FUNC_START: begin
            if (!sts_i.alloc_hit) begin
              if (last) status_d = ST_NO_SLOT;
              else      idx_d    = idx_q + 1'b1;
            end
          end
          default: idx_d = '0;
        endcase
      end
      S_TEVAL: begin
        if (!last) idx_d = idx_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath controls
  always_comb begin
    ctl_o.op       = OP_NONE;
    ctl_o.now_inc  = 1'b0;
    ctl_o.flag_clr = 1'b0;
    ctl_o.out_load = 1'b0;
    ctl_o.status   = status_q;
    unique case (state_q)
      S_SCAN: begin
        unique case (func_i)
          FUNC_SET:    if (sts_i.free_hit) ctl_o.op = OP_ALLOC;
          FUNC_START:  if (sts_i.alloc_hit) ctl_o.op = OP_ARM;
          FUNC_CANCEL: ctl_o.op = OP_CANCEL;
          FUNC_TICK:   ctl_o.now_inc = 1'b1;
          FUNC_CLEAR:  ctl_o.flag_clr = 1'b1;
          default: ;
        endcase
      end
      S_TEVAL: ctl_o.op = OP_EXPIRE;
      S_RESP:  ctl_o.out_load = out_free_i;
      default: ;
    endcase
  end

  // RAM read runs one slot ahead of evaluation during a tick scan
  assign idx_o    = idx_q;
  assign rd_idx_o = (state_q == S_TEVAL && !last) ? idx_q + 1'b1 : idx_q;
  assign busy_o   = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/timer_slot_table_event_flags_top.sv =====
// Top level of the timer slot table with event flags.
// Cancel, clear, read and unused codes need no scan; set and start scan the slots in index order
// up to the first hit, or to the last slot on a miss; tick scans every slot, one slot per cycle,
// through the slot RAMs.
// One item at a time: the next item is accepted only after the result has been registered.
// Asynchronous active-low reset frees all slots and clears the time counter and flags.
`default_nettype none

module timer_slot_table_event_flags_top #(
  parameter int unsigned SLOTS       = tst_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS   = tst_pkg::TIME_BITS_DEF,
  parameter int unsigned EVENT_COUNT = tst_pkg::EVENT_COUNT_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [tst_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [tst_pkg::ID_W-1:0]       timer_id_i,
  input  wire logic [tst_pkg::DUR_W-1:0]      duration_i,
  input  wire logic [tst_pkg::EV_W-1:0]       event_id_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [tst_pkg::FLAGS_W-1:0]    event_flags_o,
  output logic      [tst_pkg::STATUS_W-1:0]   status_o
);

  import tst_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [63:0] TimeMax = {64{1'b1}} >> (64 - TIME_BITS);

  logic                   accept;
  logic                   busy;
  logic                   out_free;
  seq_ctl_t               ctl;
  slot_sts_t              sts;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [EV_W-1:0]        fire_ev;

  func_e                  func_q;
  logic [ID_W-1:0]        id_q;
  logic [EV_W-1:0]        ev_q;
  logic [TIME_BITS-1:0]   len_q;
  logic [63:0]            dur_wide;
  logic [TIME_BITS-1:0]   len_d;

  logic [TIME_BITS-1:0]   now_q;
  logic [EVENT_COUNT-1:0] flag_q, flag_d;

  logic                   out_valid_q;
  logic [FLAGS_W-1:0]     out_flags_q;
  status_e                out_status_q;

  assign accept     = in_valid_i && !busy;
  assign in_stall_o = busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Saturate the duration to the time counter range
  assign dur_wide = 64'(duration_i);
  assign len_d    = (dur_wide > TimeMax) ? TimeMax[TIME_BITS-1:0] : dur_wide[TIME_BITS-1:0];

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_e'(func_i);
      id_q   <= timer_id_i;
      ev_q   <= event_id_i;
      len_q  <= len_d;
    end
  end

  // Flag update; an event id beyond the flag count shifts out to nothing
  always_comb begin
    flag_d = flag_q;
    if (ctl.flag_clr) begin
      flag_d = flag_q & ~(EVENT_COUNT'(1) << ev_q);
    end else if (ctl.op == OP_EXPIRE && sts.fire) begin
      flag_d = flag_q | (EVENT_COUNT'(1) << fire_ev);
    end
  end

  // Time counter and flag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q  <= '0;
      flag_q <= '0;
    end else begin
      if (ctl.now_inc) now_q <= now_q + 1'b1;
      flag_q <= flag_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_flags_q  <= FLAGS_W'(flag_q);
      out_status_q <= ctl.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_flags_o = out_flags_q;
  assign status_o      = out_status_q;

  tst_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_q),
    .out_free_i (out_free),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .idx_o      (idx),
    .rd_idx_o   (rd_idx),
    .busy_o     (busy)
  );

  tst_slot_table #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_slot_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (ctl.op),
    .idx_i     (idx),
    .rd_idx_i  (rd_idx),
    .id_i      (id_q),
    .ev_i      (ev_q),
    .len_i     (len_q),
    .now_i     (now_q),
    .sts_o     (sts),
    .fire_ev_o (fire_ev)
  );

endmodule

`default_nettype wire

// ===== rtl/tst_checker.sv =====
// Port-level checker for the timer slot table top level, with its bind.
`default_nettype none

module tst_checker #(
  parameter int unsigned EVENT_COUNT = tst_pkg::EVENT_COUNT_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [tst_pkg::FLAGS_W-1:0]  event_flags_o,
  input wire logic [tst_pkg::STATUS_W-1:0] status_o
);

  import tst_pkg::*;

  localparam logic [FLAGS_W-1:0] FlagMask = FLAGS_W'((17'd1 << EVENT_COUNT) - 17'd1);

  // One transaction at a time: the block is busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a transaction is in progress");

  // A stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_flags_o) && $stable(status_o))
    else $error("stalled result changed");

  // Status is one of the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_NO_FREE) || (status_o == ST_NO_SLOT))
    else $error("undefined status code");

  // Flags beyond the event count stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_flags_o & ~FlagMask) == '0)
    else $error("flag set beyond event count");

endmodule

bind timer_slot_table_event_flags_top tst_checker #(
  .EVENT_COUNT (EVENT_COUNT)
) u_tst_checker (.*);

`default_nettype wire

// ===== tb/timer_slot_table_event_flags_top_tb.sv =====
// Self-checking testbench for the timer slot table with event flags.
`default_nettype none

module timer_slot_table_event_flags_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tst_pkg::*;

  localparam int unsigned SLOTS        = SLOTS_DEF;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned DRAIN_EVERY  = 600;
  localparam int unsigned IDLE_LIMIT   = 2000;

  // Codes the block decodes to nothing
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    status_e            status;
  } flag_reply_t;

  // Tracks the slot table and flag register, queues the reply each command should produce
  class flag_scoreboard;
    mode_e              slot_state [SLOTS];
    logic [ID_W-1:0]    slot_owner [SLOTS];
    logic [DUR_W-1:0]   slot_len   [SLOTS];
    logic [EV_W-1:0]    slot_event [SLOTS];
    logic [DUR_W-1:0]   slot_stamp [SLOTS];
    logic [FLAGS_W-1:0] flags;
    logic [DUR_W-1:0]   now_ticks;
    flag_reply_t        expected_q [$];
    int unsigned        mismatches;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        slot_state[s] = MODE_FREE;
        slot_owner[s] = '0;
        slot_len[s]   = '0;
        slot_event[s] = '0;
        slot_stamp[s] = '0;
      end
      flags      = '0;
      now_ticks  = '0;
      mismatches = 0;
    endfunction

    function void free_timer(logic [ID_W-1:0] id);
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_owner[s] == id) slot_state[s] = MODE_FREE;
      end
    endfunction

    function void note_command(logic [FUNC_W-1:0] fn, logic [ID_W-1:0] id,
                               logic [DUR_W-1:0] dur, logic [EV_W-1:0] ev);
      flag_reply_t      exp;
      logic [DUR_W-1:0] elapsed;
      logic             done;
      exp.status = ST_OK;
      done       = 1'b0;
      case (fn)
        FUNC_SET: begin
          // lowest free slot; time counter is as wide as the duration, so no saturation
          exp.status = ST_NO_FREE;
          for (int s = 0; s < SLOTS; s++) begin
            if (!done && slot_state[s] == MODE_FREE) begin
              slot_state[s] = MODE_ALLOC;
              slot_owner[s] = id;
              slot_stamp[s] = '0;
              slot_event[s] = ev;
              slot_len[s]   = dur;
              exp.status    = ST_OK;
              done          = 1'b1;
            end
          end
        end
        FUNC_START: begin
          // lowest allocated or running slot with the id is (re)stamped
          exp.status = ST_NO_SLOT;
          for (int s = 0; s < SLOTS; s++) begin
            if (!done && slot_state[s] != MODE_FREE && slot_owner[s] == id) begin
              slot_state[s] = MODE_RUN;
              slot_stamp[s] = now_ticks;
              exp.status    = ST_OK;
              done          = 1'b1;
            end
          end
        end
        FUNC_CANCEL: free_timer(id);
        FUNC_TICK: begin
          // advance time, then scan in slot order; a slot freed earlier in the scan is skipped
          now_ticks = now_ticks + 1'b1;
          for (int s = 0; s < SLOTS; s++) begin
            if (slot_state[s] == MODE_RUN) begin
              elapsed = now_ticks - slot_stamp[s];
              if (elapsed >= slot_len[s]) begin
                if (slot_event[s] < EVENT_COUNT_DEF) flags[slot_event[s]] = 1'b1;
                free_timer(slot_owner[s]);
              end
            end
          end
        end
        FUNC_CLEAR: begin
          if (ev < EVENT_COUNT_DEF) flags[ev] = 1'b0;
        end
        default: ;
      endcase
      exp.flags = flags;
      expected_q.push_back(exp);
    endfunction

    function void check_reply(logic [FLAGS_W-1:0] got_flags, logic [STATUS_W-1:0] got_status);
      flag_reply_t exp;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, flags %h status %0d", $time, got_flags, got_status);
        mismatches++;
      end else begin
        exp = expected_q.pop_front();
        if (got_flags !== exp.flags) begin
          $display("%0t: event_flags expected %h, actual %h", $time, exp.flags, got_flags);
          mismatches++;
        end
        if (got_status !== exp.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, exp.status, got_status);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func        = '0;
  logic [ID_W-1:0]     timer_id    = '0;
  logic [DUR_W-1:0]    duration    = '0;
  logic [EV_W-1:0]     event_id    = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [FLAGS_W-1:0]  event_flags;
  logic [STATUS_W-1:0] status;

  flag_scoreboard sb;
  logic           drive_valid = 1'b0;
  int unsigned    items_sent  = 0;
  int unsigned    burst_left  = 1;
  logic [2:0]     stall_mode  = '0;
  logic [7:0]     stall_cycle = '0;
  int unsigned    idle_cycles = 0;

  timer_slot_table_event_flags_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .timer_id_i    (timer_id),
    .duration_i    (duration),
    .event_id_i    (event_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .event_flags_o (event_flags),
    .status_o      (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern, switching style each time the 8-bit cycle counter wraps
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1'b1;
    if (stall_cycle == '0) stall_mode <= 3'($urandom_range(0, 3));
    case (stall_mode)
      3'd0:    out_stall <= 1'b0;
      3'd1:    out_stall <= ($urandom_range(0, 2) == 0);
      3'd2:    out_stall <= (stall_cycle[3:0] < 4'd5);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Transaction monitor on both channels
  always @(posedge clk) begin
    if (in_valid && !in_stall) sb.note_command(func, timer_id, duration, event_id);
    if (out_valid && !out_stall) sb.check_reply(event_flags, status);
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timer_slot_table_event_flags_top_tb NOT OK");
    $finish;
  end

  task automatic hold_off();
    if (drive_valid) begin
      in_valid    <= 1'b0;
      drive_valid = 1'b0;
    end
  endtask

  // Present one command, hold it until accepted, then maybe pause between bursts
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
                          input logic [DUR_W-1:0] dur, input logic [EV_W-1:0] ev);
    int unsigned gap;
    in_valid    <= 1'b1;
    func        <= fn;
    timer_id    <= id;
    duration    <= dur;
    event_id    <= ev;
    drive_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fn != FUNC_UNUSED_A && fn != FUNC_UNUSED_B) items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        hold_off();
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait on the clock first so the monitor has noted the last accepted transaction
  task automatic wait_drained();
    hold_off();
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // One timer life: set, usually start, some ticks, then often a follow-up access
  task automatic timer_sequence();
    logic [ID_W-1:0]  id;
    logic [EV_W-1:0]  ev;
    logic [DUR_W-1:0] dur;
    int unsigned      n_ticks;
    int unsigned      tail;
    id  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
    ev  = 4'($urandom_range(0, 15));
    dur = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 6));
    send_cmd(FUNC_SET, id, dur, ev);
    if ($urandom_range(0, 4) != 0) send_cmd(FUNC_START, id, $urandom(), 4'($urandom()));
    n_ticks = $urandom_range(0, 8);
    repeat (n_ticks) send_cmd(FUNC_TICK, 4'($urandom()), $urandom(), 4'($urandom()));
    tail = $urandom_range(0, 5);
    case (tail)
      0, 1: send_cmd(FUNC_CLEAR, 4'($urandom()), $urandom(), ev);
      2:    send_cmd(FUNC_CLEAR, 4'($urandom()), $urandom(), 4'($urandom()));
      3:    send_cmd(FUNC_READ, 4'($urandom()), $urandom(), 4'($urandom()));
      4:    send_cmd(FUNC_CANCEL, id, $urandom(), 4'($urandom()));
      default: ;
    endcase
  endtask

  initial begin
    int unsigned base;
    int unsigned next_drain;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unused codes, misses, full table, restart, expiry freeing shared ids
    send_cmd(FUNC_READ, 4'd0, 32'd0, 4'd0);
    send_cmd(FUNC_UNUSED_A, 4'hF, 32'hFFFF_FFFF, 4'hF);
    send_cmd(FUNC_UNUSED_B, 4'h5, 32'h5555_5555, 4'hA);
    send_cmd(FUNC_START, 4'd9, 32'd0, 4'd0);
    send_cmd(FUNC_CANCEL, 4'd9, 32'd0, 4'd0);
    send_cmd(FUNC_CLEAR, 4'd0, 32'd0, 4'd15);
    for (int s = 0; s < SLOTS; s++) begin
      send_cmd(FUNC_SET, 4'(s % 8),
               (s == 0) ? 32'd0 : (s == 1) ? 32'hFFFF_FFFF : 32'(s), 4'(15 - s));
    end
    send_cmd(FUNC_SET, 4'd15, 32'h8000_0001, 4'd0);
    send_cmd(FUNC_START, 4'd0, 32'd0, 4'd0);
    send_cmd(FUNC_START, 4'd0, 32'd0, 4'd0);
    send_cmd(FUNC_TICK, 4'd0, 32'd0, 4'd0);
    send_cmd(FUNC_CLEAR, 4'd0, 32'd0, 4'd15);
    send_cmd(FUNC_CANCEL, 4'd1, 32'd0, 4'd0);
    wait_drained();

    // Random: mostly timer lives, some unrestricted commands
    base       = items_sent;
    next_drain = DRAIN_EVERY;
    while (items_sent - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        timer_sequence();
      end else begin
        send_cmd(3'($urandom_range(0, 7)), 4'($urandom()), $urandom(), 4'($urandom()));
      end
      if (items_sent - base >= next_drain) begin
        wait_drained();
        next_drain += DRAIN_EVERY;
      end
    end

    wait_drained();
    repeat (SLOTS + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("timer_slot_table_event_flags_top_tb OK");
    end else begin
      $display("timer_slot_table_event_flags_top_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
